// ----- hdl/modbus_tcp_request_framer_macros.svh -----
// Assertion macros for the request framer
`ifndef MODBUS_TCP_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_TCP_REQUEST_FRAMER_MACROS_SVH

// same-cycle implication, reset masks the check
`define MTRF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked on the following edge
`define MTRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mtrf_pkg.sv -----
package mtrf_pkg;

	// request modes
	localparam logic [2:0] MODE_RD_COILS    = 3'd0;
	localparam logic [2:0] MODE_RD_DISCRETE = 3'd1;
	localparam logic [2:0] MODE_RD_HOLDING  = 3'd2;
	localparam logic [2:0] MODE_RD_INPUT    = 3'd3;
	localparam logic [2:0] MODE_WR_COIL     = 3'd4;
	localparam logic [2:0] MODE_WR_REG      = 3'd5;
	localparam logic [2:0] MODE_WR_COILS    = 3'd6;
	localparam logic [2:0] MODE_WR_REGS     = 3'd7;

	// item kinds
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	// multi-write quantity limits
	localparam logic [15:0] MAX_REGS  = 16'd123;
	localparam logic [15:0] MAX_COILS = 16'd1968;

	// MBAP length of a twelve byte frame, and base length of a multi write
	localparam logic [7:0] LEN_FIXED = 8'd6;
	localparam logic [7:0] LEN_MULTI = 8'd7;

	localparam logic [7:0] COIL_ON = 8'hFF;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_COILS,
		PH_REGS
	} phase_t;

	typedef enum logic [1:0] {
		JOB_HDR,
		JOB_ERR,
		JOB_DATA
	} job_kind_t;

	// one unit of work for the byte sequencer
	typedef struct packed {
		job_kind_t   kind;
		logic [2:0]  mode;
		logic [15:0] txn;
		logic [7:0]  unit;
		logic [15:0] qv;        // quantity/value, or data word for data jobs
		logic [7:0]  count;     // byte count of a multi write
		logic        two_bytes; // data job emits hi then lo byte
		logic        last;      // data job closes the frame
		logic [15:0] pend_addr;
		logic [15:0] pend_qty;
	} job_t;

	function automatic logic [7:0] fcode(input logic [2:0] mode);
		logic [7:0] f;
		case (mode)
			MODE_RD_COILS:    f = 8'd1;
			MODE_RD_DISCRETE: f = 8'd2;
			MODE_RD_HOLDING:  f = 8'd3;
			MODE_RD_INPUT:    f = 8'd4;
			MODE_WR_COIL:     f = 8'd5;
			MODE_WR_REG:      f = 8'd6;
			MODE_WR_COILS:    f = 8'd15;
			MODE_WR_REGS:     f = 8'd16;
			default:          f = 8'd0;
		endcase
		return f;
	endfunction

endpackage

// ----- hdl/mtrf_front.sv -----
module mtrf_front import mtrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        item_kind,
	input  logic [2:0]  mode,
	input  logic [15:0] txn_id,
	input  logic [7:0]  unit_id,
	input  logic [15:0] start_addr,
	input  logic [15:0] quantity_or_value,
	input  logic [15:0] data_value,
	output logic        push,
	output job_t        job
);

	logic [15:0] rem_addr_q, rem_qty_q;
	logic [10:0] left_q;
	logic [7:0]  acc_q;
	logic [2:0]  pos_q;
	phase_t      phase_q;

	logic [15:0] rem_addr_d, rem_qty_d;
	logic [10:0] left_d;
	logic [7:0]  acc_d;
	logic [2:0]  pos_d;
	phase_t      phase_d;

	logic        multi, qty_bad, fire;
	logic [7:0]  count;
	logic [7:0]  acc_new;
	logic [10:0] left_dec;
	logic        left_last;

	assign multi    = (mode == MODE_WR_COILS) || (mode == MODE_WR_REGS);
	assign qty_bad  = (quantity_or_value == 16'd0) ||
		(quantity_or_value > ((mode == MODE_WR_REGS) ? MAX_REGS : MAX_COILS));
	// 2*qty for registers, ceil(qty/8) for coils; both stay below 256 when in range
	assign count    = (mode == MODE_WR_REGS) ? {quantity_or_value[6:0], 1'b0}
		: 8'((quantity_or_value + 16'd7) >> 3);
	assign acc_new  = acc_q | (8'(data_value[0]) << pos_q);
	assign left_dec = left_q - 11'd1;
	assign left_last = (left_q == 11'd1);

	// classify the item and build the job for the sequencer
	always_comb begin
		rem_addr_d = rem_addr_q;
		rem_qty_d  = rem_qty_q;
		left_d     = left_q;
		acc_d      = acc_q;
		pos_d      = pos_q;
		phase_d    = phase_q;
		fire       = 1'b0;
		job        = '0;
		job.kind   = JOB_DATA;
		job.mode   = mode;
		job.txn    = txn_id;
		job.unit   = unit_id;
		job.count  = count;
		job.pend_addr = rem_addr_q;
		job.pend_qty  = rem_qty_q;
		if (item_kind == KIND_HEADER) begin
			phase_d = PH_NONE;
			left_d  = '0;
			acc_d   = '0;
			pos_d   = '0;
			fire    = 1'b1;
			if (multi && qty_bad) begin
				job.kind = JOB_ERR;
				job.last = 1'b1;
			end else begin
				job.kind   = JOB_HDR;
				job.qv     = quantity_or_value;
				rem_addr_d = start_addr;
				if (!((mode == MODE_WR_COIL) || (mode == MODE_WR_REG)))
					rem_qty_d = quantity_or_value;
				job.pend_addr = rem_addr_d;
				job.pend_qty  = rem_qty_d;
				if (multi) begin
					left_d  = quantity_or_value[10:0];
					phase_d = (mode == MODE_WR_REGS) ? PH_REGS : PH_COILS;
				end
			end
		end else if (phase_q == PH_REGS && left_q != '0) begin
			left_d        = left_dec;
			fire          = 1'b1;
			job.qv        = data_value;
			job.two_bytes = 1'b1;
			job.last      = left_last;
			if (left_last)
				phase_d = PH_NONE;
		end else if (phase_q == PH_COILS && left_q != '0) begin
			left_d = left_dec;
			acc_d  = acc_new;
			pos_d  = pos_q + 3'd1;
			if (pos_q == 3'd7 || left_last) begin
				fire     = 1'b1;
				job.qv   = {8'h00, acc_new};
				job.last = left_last;
				acc_d    = '0;
				pos_d    = '0;
				if (left_last)
					phase_d = PH_NONE;
			end
		end else begin
			// stray data item
			phase_d = PH_NONE;
		end
	end

	assign push = accept && fire;

	// front state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_addr_q <= '0;
			rem_qty_q  <= '0;
			left_q     <= '0;
			acc_q      <= '0;
			pos_q      <= '0;
			phase_q    <= PH_NONE;
		end else if (accept) begin
			rem_addr_q <= rem_addr_d;
			rem_qty_q  <= rem_qty_d;
			left_q     <= left_d;
			acc_q      <= acc_d;
			pos_q      <= pos_d;
			phase_q    <= phase_d;
		end
	end

endmodule

// ----- hdl/mtrf_fifo.sv -----
module mtrf_fifo import mtrf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == FULL_CNT);
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// ----- hdl/mtrf_back.sv -----
module mtrf_back import mtrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_valid,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);

	logic [3:0]  step_q;
	logic        out_valid_q, out_last_q, out_err_q;
	logic [7:0]  out_byte_q;
	logic [15:0] out_addr_q, out_qty_q;

	logic        advance, multi;
	logic [3:0]  last_step;
	logic [7:0]  byte_d, len;
	logic        last_d, err_d;

	assign advance = job_valid && (!out_valid_q || m_tready);
	assign multi   = (job.mode == MODE_WR_COILS) || (job.mode == MODE_WR_REGS);
	assign len     = multi ? LEN_MULTI + job.count : LEN_FIXED;
	assign pop     = advance && (step_q == last_step);

	// byte selection for the current step of the job
	always_comb begin
		byte_d    = '0;
		last_d    = 1'b0;
		err_d     = 1'b0;
		last_step = '0;
		case (job.kind)
			JOB_HDR: begin
				last_step = multi ? 4'd12 : 4'd11;
				last_d    = !multi && (step_q == 4'd11);
				case (step_q)
					4'd0:    byte_d = job.txn[15:8];
					4'd1:    byte_d = job.txn[7:0];
					4'd5:    byte_d = len;
					4'd6:    byte_d = job.unit;
					4'd7:    byte_d = fcode(job.mode);
					4'd8:    byte_d = job.pend_addr[15:8];
					4'd9:    byte_d = job.pend_addr[7:0];
					4'd10:   byte_d = (job.mode == MODE_WR_COIL)
						? ((job.qv != '0) ? COIL_ON : 8'h00) : job.qv[15:8];
					4'd11:   byte_d = (job.mode == MODE_WR_COIL) ? 8'h00 : job.qv[7:0];
					4'd12:   byte_d = job.count;
					default: byte_d = 8'h00; // protocol id and length high byte
				endcase
			end
			JOB_ERR: begin
				last_d = 1'b1;
				err_d  = 1'b1;
			end
			JOB_DATA: begin
				last_step = job.two_bytes ? 4'd1 : 4'd0;
				byte_d    = (job.two_bytes && step_q == 4'd0) ? job.qv[15:8] : job.qv[7:0];
				last_d    = job.last && (step_q == last_step);
			end
			default: ;
		endcase
	end

	// step counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				step_q <= pop ? '0 : step_q + 4'd1;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
			out_err_q  <= err_d;
			out_addr_q <= job.pend_addr;
			out_qty_q  <= job.pend_qty;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_qty_q, out_addr_q, out_byte_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

// ----- hdl/modbus_tcp_request_framer.sv -----
// Channel | Dir | tdata (low bit up)                              | tuser (low bit up)
// s_*     | in  | txn_id, unit_id, start_addr, quantity_or_value, | item_kind, mode
//         |     | data_value                                      |
// m_*     | out | frame_byte, pending_addr, pending_qty           | quantity_error
//
// An input item is taken in the cycle it arrives as long as the job queue has room.
// The byte sequencer emits one byte per cycle while a job is queued and m_tready is high:
// a header is 12 or 13 bytes, a register item 2, a completed coil byte or an error result 1.
// A stall on m_tready backs up the queue; s_tready drops only when the queue is full.
// Asynchronous reset clears all request state; no clearing pass is needed.
`include "modbus_tcp_request_framer_macros.svh"

module modbus_tcp_request_framer import mtrf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // txn_id, unit_id, start_addr, quantity_or_value, data_value
	input  logic [3:0]  s_tuser,  // item_kind, mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // frame_byte, pending_addr, pending_qty
	output logic        m_tlast,
	output logic        m_tuser   // quantity_error
);

	logic accept, q_push, q_pop, q_full, q_empty;
	job_t front_job, head_job;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	mtrf_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.item_kind         (s_tuser[0]),
		.mode              (s_tuser[3:1]),
		.txn_id            (s_tdata[15:0]),
		.unit_id           (s_tdata[23:16]),
		.start_addr        (s_tdata[39:24]),
		.quantity_or_value (s_tdata[55:40]),
		.data_value        (s_tdata[71:56]),
		.push              (q_push),
		.job               (front_job)
	);

	mtrf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (front_job),
		.pop    (q_pop),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	mtrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (!q_empty),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// error results are single zero bytes that close the frame
	`MTRF_ASSERT_NOW(a_err_last, m_tvalid && m_tuser, m_tlast && (m_tdata[7:0] == 8'h00), "error result not a closing zero byte")
	// the sequencer never takes a job from an empty queue
	`MTRF_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "pop from empty job queue")
	// a job pushed without a pop leaves the queue occupied
	`MTRF_ASSERT_NEXT(a_push_fill, q_push && !q_pop, !q_empty, "pushed job lost from queue")

endmodule

// ----- sim/modbus_tcp_request_framer_tb.sv -----
`timescale 1ns / 100ps

module modbus_tcp_request_framer_tb;
	import mtrf_pkg::*;

	// Modbus function codes as they appear on the wire
	localparam logic [7:0] FC_READ_COILS     = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
	localparam logic [7:0] FC_READ_INPUT     = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
	localparam logic [7:0] FC_WRITE_REG      = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

	localparam int MAX_GAP      = 12;
	localparam int RANDOM_ITEMS = 190;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic        kind;
		logic [2:0]  mode;
		logic [15:0] txn;
		logic [7:0]  uid;
		logic [15:0] addr;
		logic [15:0] qv;
		logic [15:0] word;
	} request_t;

	typedef struct packed {
		logic [7:0]  fbyte;
		logic        last;
		logic        err;
		logic [15:0] addr;
		logic [15:0] qty;
	} frame_out_t;

	typedef struct packed {
		request_t   req;
		logic       typed;
		frame_out_t want;
	} plan_row_t;

	localparam frame_out_t NO_WANT = '0;
	// error transfer while nothing has been remembered yet
	localparam frame_out_t ERR_AT_RESET = '{8'h00, 1'b1, 1'b1, 16'h0000, 16'h0000};

	localparam int N_PLAN = 25;
	localparam plan_row_t PLAN [N_PLAN] = '{
		// bad multi-write quantities right after reset
		'{'{KIND_HEADER, MODE_WR_REGS, 16'h0001, 8'h01, 16'h0010, 16'h0000, 16'h0000}, 1'b1, ERR_AT_RESET},
		'{'{KIND_HEADER, MODE_WR_COILS, 16'h0002, 8'h02, 16'h0020, 16'h07B1, 16'h0000}, 1'b1, ERR_AT_RESET},
		'{'{KIND_HEADER, MODE_WR_REGS, 16'h0003, 8'h03, 16'h0030, 16'h007C, 16'h0000}, 1'b1, ERR_AT_RESET},
		// data with nothing pending
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, NO_WANT},
		// plain twelve byte frames, field extremes
		'{'{KIND_HEADER, MODE_RD_COILS, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_WANT},
		'{'{KIND_HEADER, MODE_RD_DISCRETE, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_HEADER, MODE_RD_HOLDING, 16'h1234, 8'h11, 16'h0100, 16'h007D, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_HEADER, MODE_RD_INPUT, 16'h8000, 8'h80, 16'h8000, 16'h8000, 16'h0000}, 1'b0, NO_WANT},
		// single writes keep the remembered quantity
		'{'{KIND_HEADER, MODE_WR_COIL, 16'h4321, 8'h05, 16'h0007, 16'h0000, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_HEADER, MODE_WR_COIL, 16'h4322, 8'h06, 16'h0008, 16'h0001, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_HEADER, MODE_WR_REG, 16'h5555, 8'hAA, 16'hAAAA, 16'h5555, 16'h0000}, 1'b0, NO_WANT},
		// two registers, then a stray word after the frame closed
		'{'{KIND_HEADER, MODE_WR_REGS, 16'h0101, 8'h01, 16'h0200, 16'h0002, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h8001}, 1'b0, NO_WANT},
		// nine coils: one full byte and a padded last byte
		'{'{KIND_HEADER, MODE_WR_COILS, 16'h0202, 8'h02, 16'h0300, 16'h0009, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0001}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'hFFFE}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0001}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'hAAAA}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h5555}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0003}, 1'b0, NO_WANT},
		'{'{KIND_DATA, MODE_RD_COILS, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0001}, 1'b0, NO_WANT}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // txn_id, unit_id, start_addr, quantity_or_value, data_value
	logic [3:0]  s_tuser;  // item_kind, mode
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // frame_byte, pending_addr, pending_qty
	logic        m_tlast;
	logic        m_tuser;  // quantity_error

	// predicted framer state
	logic [15:0] addr_held;
	logic [15:0] qty_held;
	logic [15:0] elems_due;
	logic [7:0]  coil_acc;
	logic [3:0]  coil_pos;
	phase_t      phase;

	frame_out_t frames_due [$];

	int mismatches;
	int n_headers;
	int n_data;
	int n_strays;
	int n_transfers;
	int n_err_seen;
	bit tx_calm;
	int rx_calm_left;

	modbus_tcp_request_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// watchdog
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] function_code(input logic [2:0] mode);
		case (mode)
			MODE_RD_COILS:    return FC_READ_COILS;
			MODE_RD_DISCRETE: return FC_READ_DISCRETE;
			MODE_RD_HOLDING:  return FC_READ_HOLDING;
			MODE_RD_INPUT:    return FC_READ_INPUT;
			MODE_WR_COIL:     return FC_WRITE_COIL;
			MODE_WR_REG:      return FC_WRITE_REG;
			MODE_WR_COILS:    return FC_WRITE_COILS;
			default:          return FC_WRITE_REGS;
		endcase
	endfunction

	function automatic frame_out_t frame_entry(input logic [7:0] b, input logic last,
		input logic err);
		frame_out_t e;
		e.fbyte = b;
		e.last  = last;
		e.err   = err;
		e.addr  = addr_held;
		e.qty   = qty_held;
		return e;
	endfunction

	// work out the frame bytes caused by one accepted request and queue them
	task automatic predict_frame_bytes(input request_t r);
		logic [7:0]  hb [13];
		logic [15:0] limit;
		logic [15:0] cnt;
		logic        multi;
		logic        closes;
		int          n;
		cnt   = '0;
		multi = (r.mode == MODE_WR_COILS) || (r.mode == MODE_WR_REGS);
		if (r.kind == KIND_HEADER) begin
			// any header drops an unfinished data phase
			phase     = PH_NONE;
			elems_due = '0;
			coil_acc  = '0;
			coil_pos  = '0;
			if (multi) begin
				limit = (r.mode == MODE_WR_REGS) ? MAX_REGS : MAX_COILS;
				if (r.qv == 16'd0 || r.qv > limit) begin
					frames_due.push_back(frame_entry(8'h00, 1'b1, 1'b1));
					return;
				end
				cnt = (r.mode == MODE_WR_REGS) ? r.qv * 16'd2 : (r.qv + 16'd7) / 16'd8;
			end
			addr_held = r.addr;
			if (r.mode != MODE_WR_COIL && r.mode != MODE_WR_REG)
				qty_held = r.qv;
			hb[0] = r.txn[15:8];
			hb[1] = r.txn[7:0];
			hb[2] = 8'h00;
			hb[3] = 8'h00;
			hb[4] = 8'h00;
			hb[5] = multi ? LEN_MULTI + cnt[7:0] : LEN_FIXED;
			hb[6] = r.uid;
			hb[7] = function_code(r.mode);
			hb[8] = r.addr[15:8];
			hb[9] = r.addr[7:0];
			if (r.mode == MODE_WR_COIL) begin
				hb[10] = (r.qv != 16'd0) ? COIL_ON : 8'h00;
				hb[11] = 8'h00;
			end else begin
				hb[10] = r.qv[15:8];
				hb[11] = r.qv[7:0];
			end
			n = 12;
			if (multi) begin
				hb[12]    = cnt[7:0];
				n         = 13;
				elems_due = r.qv;
				phase     = (r.mode == MODE_WR_REGS) ? PH_REGS : PH_COILS;
			end
			for (int i = 0; i < n; i++)
				frames_due.push_back(frame_entry(hb[i], !multi && (i == n - 1), 1'b0));
		end else if (phase == PH_REGS && elems_due != 16'd0) begin
			elems_due = elems_due - 16'd1;
			closes = (elems_due == 16'd0);
			if (closes)
				phase = PH_NONE;
			frames_due.push_back(frame_entry(r.word[15:8], 1'b0, 1'b0));
			frames_due.push_back(frame_entry(r.word[7:0], closes, 1'b0));
		end else if (phase == PH_COILS && elems_due != 16'd0) begin
			// coils pack LSB first, a short last byte is zero padded
			coil_acc  = coil_acc | (8'(r.word[0]) << coil_pos[2:0]);
			coil_pos  = coil_pos + 4'd1;
			elems_due = elems_due - 16'd1;
			closes = (elems_due == 16'd0);
			if (coil_pos >= 4'd8 || closes) begin
				if (closes)
					phase = PH_NONE;
				frames_due.push_back(frame_entry(coil_acc, closes, 1'b0));
				coil_acc = '0;
				coil_pos = '0;
			end
		end else begin
			phase = PH_NONE;
		end
	endtask

	// one input transfer, with a random hold-off in front of it
	task automatic send_request(input request_t r, input logic typed, input frame_out_t want);
		int gap;
		int n0;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.word, r.qv, r.addr, r.uid, r.txn};
		s_tuser  <= {r.mode, r.kind};
		do @(posedge clk); while (!s_tready);
		n0 = frames_due.size();
		predict_frame_bytes(r);
		if (typed) begin
			while (frames_due.size() > n0)
				void'(frames_due.pop_back());
			frames_due.push_back(want);
		end
		if (r.kind == KIND_HEADER)
			n_headers++;
		else if (frames_due.size() == n0 && phase == PH_NONE)
			n_strays++;
		else
			n_data++;
	endtask

	function automatic request_t random_request();
		request_t r;
		r.kind = 1'($urandom_range(0, 1));
		r.mode = 3'($urandom_range(0, 7));
		r.txn  = 16'($urandom);
		r.uid  = 8'($urandom);
		r.addr = 16'($urandom);
		r.qv   = 16'($urandom);
		r.word = 16'($urandom);
		return r;
	endfunction

	// header of a multi write followed by some of its data words
	task automatic send_multi_write(input logic [2:0] mode, input logic [15:0] qty,
		input int words);
		request_t r;
		r      = random_request();
		r.kind = KIND_HEADER;
		r.mode = mode;
		r.qv   = qty;
		send_request(r, 1'b0, NO_WANT);
		for (int i = 0; i < words; i++) begin
			r      = random_request();
			r.kind = KIND_DATA;
			send_request(r, 1'b0, NO_WANT);
		end
	endtask

	// idle the input side until every expected transfer has come out
	task automatic wait_for_frames();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0) @(posedge clk);
	endtask

	task automatic run_random_traffic();
		request_t    r;
		int          pick;
		int          words;
		int          counted;
		logic [2:0]  mode;
		logic [15:0] qty;
		bit          did_big_regs;
		bit          did_big_coils;
		counted       = 0;
		did_big_regs  = 0;
		did_big_coils = 0;
		// let the output side empty before the random traffic starts
		wait_for_frames();
		while (counted < RANDOM_ITEMS) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (!did_big_regs && counted >= 40) begin
				// largest register write, sent with the output side idle first
				wait_for_frames();
				send_multi_write(MODE_WR_REGS, MAX_REGS, MAX_REGS);
				did_big_regs = 1;
				counted += 1 + MAX_REGS;
			end else if (!did_big_coils && counted >= 100) begin
				// largest coil header, cut off by the next header
				send_multi_write(MODE_WR_COILS, MAX_COILS, 20);
				r      = random_request();
				r.kind = KIND_HEADER;
				r.mode = 3'($urandom_range(0, 5));
				send_request(r, 1'b0, NO_WANT);
				did_big_coils = 1;
				counted += 22;
			end else if (pick < 45) begin
				mode  = $urandom_range(0, 1) ? MODE_WR_REGS : MODE_WR_COILS;
				qty   = (mode == MODE_WR_REGS) ? 16'($urandom_range(1, 6))
					: 16'($urandom_range(1, 24));
				words = qty;
				if ($urandom_range(0, 6) == 0)
					words = $urandom_range(0, qty - 1);
				send_multi_write(mode, qty, words);
				counted += 1 + words;
			end else if (pick < 75) begin
				r      = random_request();
				r.kind = KIND_HEADER;
				r.mode = 3'($urandom_range(0, 5));
				send_request(r, 1'b0, NO_WANT);
				counted++;
			end else if (pick < 85) begin
				// out of range multi-write quantities
				r      = random_request();
				r.kind = KIND_HEADER;
				r.mode = $urandom_range(0, 1) ? MODE_WR_REGS : MODE_WR_COILS;
				if ($urandom_range(0, 2) == 0)
					r.qv = 16'd0;
				else if (r.mode == MODE_WR_REGS)
					r.qv = 16'($urandom_range(MAX_REGS + 1, 16'hFFFF));
				else
					r.qv = 16'($urandom_range(MAX_COILS + 1, 16'hFFFF));
				send_request(r, 1'b0, NO_WANT);
				counted++;
			end else if (pick < 92) begin
				// noise: fully random item, a data item is often stray here
				r = random_request();
				send_request(r, 1'b0, NO_WANT);
				if (r.kind == KIND_HEADER)
					counted++;
			end else begin
				// stray data with no frame open
				wait_for_frames();
				r      = random_request();
				r.kind = KIND_DATA;
				if (phase == PH_NONE)
					send_request(r, 1'b0, NO_WANT);
			end
		end
	endtask

	// receiver: random stalls, with stretches of full throughput
	initial begin
		int stall;
		m_tready     <= 1'b0;
		rx_calm_left = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_calm_left > 0) begin
				stall = 0;
				rx_calm_left--;
			end else if ($urandom_range(0, 9) == 0) begin
				stall = 0;
				rx_calm_left = 24;
			end else begin
				stall = $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// output checker
	always @(posedge clk) begin
		frame_out_t got;
		frame_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tlast, m_tuser, m_tdata[23:8], m_tdata[39:24]};
			n_transfers++;
			if (got.err)
				n_err_seen++;
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected transfer byte=%h last=%b err=%b addr=%h qty=%h",
						$realtime, got.fbyte, got.last, got.err, got.addr, got.qty);
			end else begin
				want = frames_due.pop_front();
				if (got.fbyte !== want.fbyte || got.last !== want.last || got.err !== want.err
					|| got.addr !== want.addr || got.qty !== want.qty) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: transfer %0d exp byte=%h last=%b err=%b addr=%h qty=%h,",
							" got byte=%h last=%b err=%b addr=%h qty=%h"},
							$realtime, n_transfers, want.fbyte, want.last, want.err, want.addr,
							want.qty, got.fbyte, got.last, got.err, got.addr, got.qty);
				end
			end
		end
	end

	initial begin
		int waited;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		arst_n      <= 1'b0;
		addr_held   = '0;
		qty_held    = '0;
		elems_due   = '0;
		coil_acc    = '0;
		coil_pos    = '0;
		phase       = PH_NONE;
		mismatches  = 0;
		n_headers   = 0;
		n_data      = 0;
		n_strays    = 0;
		n_transfers = 0;
		n_err_seen  = 0;
		tx_calm     = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_PLAN; i++)
			send_request(PLAN[i].req, PLAN[i].typed, PLAN[i].want);

		run_random_traffic();
		s_tvalid <= 1'b0;

		// drain, then a short quiet tail
		waited = 0;
		while (frames_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);

		$display("Sent %0d headers, %0d data words and %0d stray words; %0d quantity errors seen.",
			n_headers, n_data, n_strays, n_err_seen);
		$display("Checked %0d output transfers, %0d mismatches, %0d still outstanding.",
			n_transfers, mismatches, frames_due.size());
		if (mismatches == 0 && frames_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
